### design/sra_pkg.sv
// Shared types and constants for the server registry with identifier allocator.
// Used by sra_ctrl, sra_dpath and server_registry_with_id_allocator.
`timescale 1ns / 1ps

package sra_pkg;

  // Table size; identifier 0 is reserved, so MAX_IDS-1 entries at most
  localparam int MAX_IDS = 64;
  localparam int ID_W    = $clog2(MAX_IDS);
  localparam int CNT_W   = $clog2(MAX_IDS + 1);

  // Field widths
  localparam int REQ_W     = 2;
  localparam int IP_W      = 32;
  localparam int PORT_W    = 16;
  localparam int KEY_W     = IP_W + PORT_W;
  localparam int HDL_W     = 16;
  localparam int STATUS_W  = 4;
  localparam int SRV_ID_W  = 6;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_FIELDS_W = STATUS_W + SRV_ID_W + 1 + HDL_W;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_CONNECT    = 2'd0,
    REQ_DISCONNECT = 2'd1,
    REQ_REMOVE     = 2'd2,
    REQ_FIND       = 2'd3
  } req_t;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_RECONNECTED  = 4'd0;
  localparam logic [STATUS_W-1:0] ST_ADDED        = 4'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY      = 4'd2;
  localparam logic [STATUS_W-1:0] ST_FULL         = 4'd3;
  localparam logic [STATUS_W-1:0] ST_DISCONNECTED = 4'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 4'd5;
  localparam logic [STATUS_W-1:0] ST_REMOVED      = 4'd6;
  localparam logic [STATUS_W-1:0] ST_STILL_CONN   = 4'd7;
  localparam logic [STATUS_W-1:0] ST_FOUND        = 4'd8;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture the request and restart the key scan
    logic scan_step;  // read one slot and compare the previous one
    logic commit;     // update the table and load the result register
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_done;  // key found or last slot compared
    logic out_free;   // result register can take a new item
  } dp_stat_t;

endpackage

### design/sra_ctrl.sv
// Controller state machine of the server registry.
// Depends on sra_pkg for the command and status structs.
`timescale 1ns / 1ps

module sra_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  sra_pkg::dp_stat_t   stat,
  output sra_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FETCH  = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  // Sequence one item: scan the keys, fetch entry data, commit
  always_comb begin
    state_next    = state;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### design/sra_dpath.sv
// Datapath of the server registry: key, handle and free-list memories,
// valid and connected bits, key scan and result register. Depends on sra_pkg.
`timescale 1ns / 1ps

module sra_dpath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sra_pkg::ctrl_cmd_t                    cmd,
  output sra_pkg::dp_stat_t                     stat,
  input  logic [sra_pkg::IN_DATA_W-1:0]         s_tdata,
  input  logic [sra_pkg::REQ_W-1:0]             s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [sra_pkg::OUT_DATA_W-1:0]        m_tdata
);

  localparam int ID_W  = sra_pkg::ID_W;
  localparam int CNT_W = sra_pkg::CNT_W;
  localparam int MAX   = sra_pkg::MAX_IDS;

  // Captured request
  sra_pkg::req_t                req_q;
  logic [sra_pkg::KEY_W-1:0]    key_q;
  logic [sra_pkg::HDL_W-1:0]    hdl_q;

  // Per-slot flags
  logic [MAX-1:0] valid_bits;
  logic [MAX-1:0] conn_bits;
  logic [MAX-1:0] fn_wr;

  // Memories
  logic [sra_pkg::KEY_W-1:0] key_mem [MAX];
  logic [sra_pkg::HDL_W-1:0] hdl_mem [MAX];
  logic [ID_W-1:0]           fn_mem  [MAX];

  // Scan state
  logic [CNT_W-1:0]          scan_cnt;
  logic [ID_W-1:0]           pend_addr;
  logic                      pend_vld;
  logic                      hit;
  logic [ID_W-1:0]           hit_id;
  logic [sra_pkg::KEY_W-1:0] key_rd;
  logic                      match;
  logic                      scan_last;

  // Entry fetch
  logic [sra_pkg::HDL_W-1:0] hdl_rd;
  logic [ID_W-1:0]           fn_rd;
  logic                      fn_rd_wr;
  logic [ID_W-1:0]           fn_rd_addr;
  logic [ID_W-1:0]           fn_dflt;
  logic [ID_W-1:0]           fn_val;
  logic [ID_W-1:0]           free_head;
  logic                      head_ok;

  // Commit decision
  logic [sra_pkg::STATUS_W-1:0] res_status;
  logic [ID_W-1:0]              res_id;
  logic                         res_conn;
  logic [sra_pkg::HDL_W-1:0]    res_hdl;
  logic                         set_conn;
  logic                         clr_conn;
  logic                         set_valid;
  logic                         clr_valid;
  logic                         wr_key;
  logic                         wr_hdl;
  logic                         wr_fn;
  logic [ID_W-1:0]              fn_waddr;
  logic [ID_W-1:0]              fn_wdata;
  logic                         head_wr;
  logic [ID_W-1:0]              head_wdata;
  logic [ID_W-1:0]              upd_addr;

  // Result register
  logic [sra_pkg::STATUS_W-1:0] out_status;
  logic [sra_pkg::SRV_ID_W-1:0] out_id;
  logic                         out_conn;
  logic [sra_pkg::HDL_W-1:0]    out_hdl;

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= sra_pkg::req_t'(s_tuser);
      key_q <= {s_tdata[sra_pkg::IP_W+sra_pkg::PORT_W-1:sra_pkg::IP_W],
                s_tdata[sra_pkg::IP_W-1:0]};
      hdl_q <= s_tdata[sra_pkg::IN_DATA_W-1:sra_pkg::KEY_W];
    end
  end

  // Compare the slot read in the previous cycle
  assign match     = pend_vld && valid_bits[pend_addr] && (key_rd == key_q);
  assign scan_last = pend_vld && (pend_addr == ID_W'(MAX - 1));
  assign stat.scan_done = match || scan_last;
  assign stat.out_free  = !m_tvalid || m_tready;

  // Walk the slots from 1 upward, one read per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      pend_vld <= 1'b0;
      hit      <= 1'b0;
    end else if (cmd.load) begin
      scan_cnt <= CNT_W'(1);
      pend_vld <= 1'b0;
      hit      <= 1'b0;
    end else if (cmd.scan_step) begin
      if (scan_cnt < CNT_W'(MAX)) begin
        pend_vld <= 1'b1;
        scan_cnt <= scan_cnt + 1'b1;
      end else begin
        pend_vld <= 1'b0;
      end
      if (match) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_id <= '0;
    end else if (cmd.scan_step && match) begin
      hit_id <= pend_addr;
    end
    pend_addr <= scan_cnt[ID_W-1:0];
    key_rd    <= key_mem[scan_cnt[ID_W-1:0]];
  end

  // Read the hit entry's handle and the free-list link behind the head
  always_ff @(posedge clk) begin
    hdl_rd     <= hdl_mem[hit_id];
    fn_rd      <= fn_mem[free_head];
    fn_rd_wr   <= fn_wr[free_head];
    fn_rd_addr <= free_head;
  end

  // A never-written link holds its reset value: next slot, last links to 0
  assign fn_dflt = (fn_rd_addr == ID_W'(MAX - 1)) ? '0 : ID_W'(fn_rd_addr + 1'b1);
  assign fn_val  = fn_rd_wr ? fn_rd : fn_dflt;
  assign head_ok = (free_head != '0) && (CNT_W'(free_head) < CNT_W'(MAX));

  // Decide the result and the table updates
  always_comb begin
    res_status = sra_pkg::ST_NOT_FOUND;
    res_id     = '0;
    res_conn   = 1'b0;
    res_hdl    = '0;
    set_conn   = 1'b0;
    clr_conn   = 1'b0;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    wr_key     = 1'b0;
    wr_hdl     = 1'b0;
    wr_fn      = 1'b0;
    fn_waddr   = hit_id;
    fn_wdata   = free_head;
    head_wr    = 1'b0;
    head_wdata = hit_id;
    upd_addr   = hit_id;
    unique case (req_q)
      sra_pkg::REQ_CONNECT: begin
        if (hit) begin
          res_id   = hit_id;
          res_conn = 1'b1;
          if (conn_bits[hit_id]) begin
            res_status = sra_pkg::ST_ALREADY;
          end else begin
            res_status = sra_pkg::ST_RECONNECTED;
            set_conn   = 1'b1;
            wr_hdl     = 1'b1;
          end
        end else if (!head_ok) begin
          res_status = sra_pkg::ST_FULL;
        end else begin
          res_status = sra_pkg::ST_ADDED;
          res_id     = free_head;
          res_conn   = 1'b1;
          upd_addr   = free_head;
          set_conn   = 1'b1;
          set_valid  = 1'b1;
          wr_key     = 1'b1;
          wr_hdl     = 1'b1;
          wr_fn      = 1'b1;
          fn_waddr   = free_head;
          fn_wdata   = '0;
          head_wr    = 1'b1;
          head_wdata = fn_val;
        end
      end
      sra_pkg::REQ_DISCONNECT: begin
        if (hit) begin
          res_status = sra_pkg::ST_DISCONNECTED;
          res_id     = hit_id;
          clr_conn   = 1'b1;
        end
      end
      sra_pkg::REQ_REMOVE: begin
        if (hit) begin
          res_id = hit_id;
          if (conn_bits[hit_id]) begin
            res_status = sra_pkg::ST_STILL_CONN;
            res_conn   = 1'b1;
          end else begin
            res_status = sra_pkg::ST_REMOVED;
            clr_valid  = 1'b1;
            wr_fn      = 1'b1;
            head_wr    = 1'b1;
          end
        end
      end
      sra_pkg::REQ_FIND: begin
        if (hit) begin
          res_status = sra_pkg::ST_FOUND;
          res_id     = hit_id;
          res_conn   = conn_bits[hit_id];
          res_hdl    = conn_bits[hit_id] ? hdl_rd : '0;
        end
      end
      default: begin
        res_status = sra_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // Apply the flag and free-head updates
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      conn_bits  <= '0;
      fn_wr      <= '0;
      free_head  <= ID_W'(1);
    end else if (cmd.commit) begin
      if (set_valid) valid_bits[upd_addr] <= 1'b1;
      if (clr_valid) valid_bits[upd_addr] <= 1'b0;
      if (set_conn)  conn_bits[upd_addr]  <= 1'b1;
      if (clr_conn)  conn_bits[upd_addr]  <= 1'b0;
      if (wr_fn)     fn_wr[fn_waddr]      <= 1'b1;
      if (head_wr)   free_head            <= head_wdata;
    end
  end

  // Write the memories
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (wr_key) key_mem[upd_addr] <= key_q;
      if (wr_hdl) hdl_mem[upd_addr] <= hdl_q;
      if (wr_fn)  fn_mem[fn_waddr]  <= fn_wdata;
    end
  end

  // Result register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status <= res_status;
      out_id     <= sra_pkg::SRV_ID_W'(res_id);
      out_conn   <= res_conn;
      out_hdl    <= res_hdl;
    end
  end

  assign m_tdata = {{(sra_pkg::OUT_DATA_W - sra_pkg::OUT_FIELDS_W){1'b0}},
                    out_hdl, out_conn, out_id, out_status};

endmodule

### design/server_registry_with_id_allocator.sv
// Server registry keyed by (address, port) with a LIFO identifier free list.
// Each item: a key scan (one slot per cycle through the key memory read port, stopping
// early on a hit), then a fetch state and a commit state. One item at a time: the next
// accept waits for the commit; a result held by m_tready low delays the commit.
// Reset (rst, synchronous): valid and connected bits cleared, free list restored.
`timescale 1ns / 1ps

module server_registry_with_id_allocator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // server_ip[31:0], server_port[47:32], conn_handle[63:48]
  input  logic [sra_pkg::IN_DATA_W-1:0]      s_tdata,
  // req_type[1:0]
  input  logic [sra_pkg::REQ_W-1:0]          s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // status[3:0], server_id[9:4], is_connected[10], handle_out[26:11], zero[31:27]
  output logic [sra_pkg::OUT_DATA_W-1:0]     m_tdata
);

  sra_pkg::ctrl_cmd_t cmd;
  sra_pkg::dp_stat_t  stat;

  sra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sra_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // One item in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while another is in flight");

  // Commit only into a free result register
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!m_tvalid || m_tready))
    else $error("result register overwritten");

  // Every commit presents a result
  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("committed result not presented");

  // Never commit while a request is being accepted or scanned
  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(cmd.load || cmd.scan_step))
    else $error("commit overlaps accept or scan");

endmodule

### dv/tb_top.sv
// Self-checking testbench for server_registry_with_id_allocator: a directed table,
// then random episodes, checked against a registry predictor kept in this file.
// Depends on sra_pkg and the design sources.
`timescale 1ns / 1ps

module tb_top;
  import sra_pkg::*;

  localparam int N_RANDOM       = 1800;
  localparam int POOL_N         = 96;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 500;
  localparam int HOLD_AT        = 200;
  localparam int DRAIN_CYCLES   = 100;
  localparam int MAX_REPORTS    = 10;

  // Expected fields of one result item
  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [SRV_ID_W-1:0] id;
    logic                conn;
    logic [HDL_W-1:0]    ho;
  } reg_result_t;

  // One directed request; typed rows carry their expected result
  typedef struct packed {
    logic [REQ_W-1:0]    req;
    logic [IP_W-1:0]     ip;
    logic [PORT_W-1:0]   port;
    logic [HDL_W-1:0]    hdl;
    logic                typed;
    logic [STATUS_W-1:0] st;
    logic [SRV_ID_W-1:0] id;
    logic                conn;
    logic [HDL_W-1:0]    ho;
  } dir_row_t;

  typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_t;

  localparam int N_DIR = 23;
  localparam dir_row_t DIR_ROWS [0:N_DIR-1] = '{
    // after reset: every lookup misses
    '{REQ_FIND,       32'h0,        16'h0,    16'h0,    1'b1, ST_NOT_FOUND,    6'd0, 1'b0, 16'h0},
    '{REQ_DISCONNECT, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1, ST_NOT_FOUND,    6'd0, 1'b0, 16'h0},
    '{REQ_REMOVE,     32'h0,        16'h0,    16'h0,    1'b1, ST_NOT_FOUND,    6'd0, 1'b0, 16'h0},
    // add the two extreme keys
    '{REQ_CONNECT,    32'h0,        16'h0,    16'h0,    1'b1, ST_ADDED,        6'd1, 1'b1, 16'h0},
    '{REQ_CONNECT,    32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1, ST_ADDED,        6'd2, 1'b1, 16'h0},
    '{REQ_CONNECT,    32'h0,        16'h0,    16'h1234, 1'b1, ST_ALREADY,      6'd1, 1'b1, 16'h0},
    '{REQ_FIND,       32'hFFFFFFFF, 16'hFFFF, 16'h0,    1'b1, ST_FOUND,        6'd2, 1'b1, 16'hFFFF},
    // remove refused while connected, double disconnect
    '{REQ_REMOVE,     32'h0,        16'h0,    16'h0,    1'b1, ST_STILL_CONN,   6'd1, 1'b1, 16'h0},
    '{REQ_DISCONNECT, 32'h0,        16'h0,    16'h0,    1'b1, ST_DISCONNECTED, 6'd1, 1'b0, 16'h0},
    '{REQ_DISCONNECT, 32'h0,        16'h0,    16'h0,    1'b1, ST_DISCONNECTED, 6'd1, 1'b0, 16'h0},
    '{REQ_FIND,       32'h0,        16'h0,    16'h0,    1'b1, ST_FOUND,        6'd1, 1'b0, 16'h0},
    // reconnect with a new handle
    '{REQ_CONNECT,    32'h0,        16'h0,    16'hABCD, 1'b0, 4'h0,            6'd0, 1'b0, 16'h0},
    '{REQ_FIND,       32'h0,        16'h0,    16'h0,    1'b0, 4'h0,            6'd0, 1'b0, 16'h0},
    '{REQ_DISCONNECT, 32'h0,        16'h0,    16'h0,    1'b0, 4'h0,            6'd0, 1'b0, 16'h0},
    '{REQ_REMOVE,     32'h0,        16'h0,    16'h0,    1'b1, ST_REMOVED,      6'd1, 1'b0, 16'h0},
    '{REQ_REMOVE,     32'h0,        16'h0,    16'h0,    1'b1, ST_NOT_FOUND,    6'd0, 1'b0, 16'h0},
    // freed id comes back first; partial key matches must miss
    '{REQ_CONNECT,    32'h12345678, 16'h9ABC, 16'h5555, 1'b0, 4'h0,            6'd0, 1'b0, 16'h0},
    '{REQ_FIND,       32'h12345678, 16'h9ABD, 16'h0,    1'b1, ST_NOT_FOUND,    6'd0, 1'b0, 16'h0},
    '{REQ_FIND,       32'h12345679, 16'h9ABC, 16'h0,    1'b1, ST_NOT_FOUND,    6'd0, 1'b0, 16'h0},
    '{REQ_DISCONNECT, 32'hFFFFFFFF, 16'hFFFF, 16'h0,    1'b0, 4'h0,            6'd0, 1'b0, 16'h0},
    '{REQ_REMOVE,     32'hFFFFFFFF, 16'hFFFF, 16'h0,    1'b0, 4'h0,            6'd0, 1'b0, 16'h0},
    '{REQ_CONNECT,    32'h0,        16'hFFFF, 16'h8000, 1'b0, 4'h0,            6'd0, 1'b0, 16'h0},
    '{REQ_FIND,       32'hFFFFFFFF, 16'h0,    16'h0,    1'b1, ST_NOT_FOUND,    6'd0, 1'b0, 16'h0}
  };

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  // server_ip[31:0], server_port[47:32], conn_handle[63:48]
  logic [IN_DATA_W-1:0]  s_tdata;
  // req_type[1:0]
  logic [REQ_W-1:0]      s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  // status[3:0], server_id[9:4], is_connected[10], handle_out[26:11], zero[31:27]
  logic [OUT_DATA_W-1:0] m_tdata;

  server_registry_with_id_allocator u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Predictor copy of the registry
  bit                slot_valid [MAX_IDS];
  logic [IP_W-1:0]   slot_ip    [MAX_IDS];
  logic [PORT_W-1:0] slot_port  [MAX_IDS];
  bit                slot_conn  [MAX_IDS];
  logic [HDL_W-1:0]  slot_hdl   [MAX_IDS];
  int                free_link  [MAX_IDS];
  int                free_top;

  reg_result_t       pending_results[$];
  int                n_fail;
  int                n_results;
  int                idle_cycles;

  logic [IP_W-1:0]   key_ip   [POOL_N];
  logic [PORT_W-1:0] key_port [POOL_N];

  // Slot holding the key, 0 when absent
  function automatic int slot_of(logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
    for (int i = 1; i < MAX_IDS; i++) begin
      if (slot_valid[i] && slot_ip[i] == ip && slot_port[i] == port) return i;
    end
    return 0;
  endfunction

  // Apply one request to the predictor and return its result item
  function automatic reg_result_t registry_step(req_t req, logic [IP_W-1:0] ip,
                                                logic [PORT_W-1:0] port,
                                                logic [HDL_W-1:0] hdl);
    reg_result_t r;
    int          sid;
    int          nid;
    sid = slot_of(ip, port);
    r   = '{ST_NOT_FOUND, '0, 1'b0, '0};
    case (req)
      REQ_CONNECT: begin
        if (sid != 0) begin
          if (slot_conn[sid]) begin
            r = '{ST_ALREADY, SRV_ID_W'(sid), 1'b1, '0};
          end else begin
            slot_conn[sid] = 1'b1;
            slot_hdl[sid]  = hdl;
            r = '{ST_RECONNECTED, SRV_ID_W'(sid), 1'b1, '0};
          end
        end else begin
          nid = free_top;
          if (nid == 0 || nid >= MAX_IDS) begin
            r = '{ST_FULL, '0, 1'b0, '0};
          end else begin
            free_top        = free_link[nid];
            free_link[nid]  = 0;
            slot_valid[nid] = 1'b1;
            slot_ip[nid]    = ip;
            slot_port[nid]  = port;
            slot_conn[nid]  = 1'b1;
            slot_hdl[nid]   = hdl;
            r = '{ST_ADDED, SRV_ID_W'(nid), 1'b1, '0};
          end
        end
      end
      REQ_DISCONNECT: begin
        if (sid != 0) begin
          slot_conn[sid] = 1'b0;
          r = '{ST_DISCONNECTED, SRV_ID_W'(sid), 1'b0, '0};
        end
      end
      REQ_REMOVE: begin
        if (sid != 0) begin
          if (slot_conn[sid]) begin
            r = '{ST_STILL_CONN, SRV_ID_W'(sid), 1'b1, '0};
          end else begin
            slot_valid[sid] = 1'b0;
            free_link[sid]  = free_top;
            free_top        = sid;
            r = '{ST_REMOVED, SRV_ID_W'(sid), 1'b0, '0};
          end
        end
      end
      default: begin
        if (sid != 0) begin
          r = '{ST_FOUND, SRV_ID_W'(sid), slot_conn[sid],
                slot_conn[sid] ? slot_hdl[sid] : '0};
        end
      end
    endcase
    return r;
  endfunction

  // Offer one request after a random gap, then record its expected result
  task automatic send_req(input req_t req, input logic [IP_W-1:0] ip,
                          input logic [PORT_W-1:0] port, input logic [HDL_W-1:0] hdl,
                          input bit typed, input reg_result_t typed_res, input bit quiet);
    int          gap;
    int          r;
    reg_result_t res;
    r   = $urandom_range(0, 99);
    gap = (quiet || r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {hdl, port, ip};
    do @(posedge clk); while (!s_tready);
    res = registry_step(req, ip, port, hdl);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Reset, once
  initial begin
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // Sender: directed table, then random episodes
  initial begin
    mix_t        mix;
    int          sent;
    int          ep_len;
    int          win;
    int          base;
    int          k;
    int          r;
    bit          quiet;
    req_t        req;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    dir_row_t    row;

    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    for (int i = 0; i < MAX_IDS; i++) begin
      slot_valid[i] = 1'b0;
      slot_conn[i]  = 1'b0;
      slot_ip[i]    = '0;
      slot_port[i]  = '0;
      slot_hdl[i]   = '0;
      free_link[i]  = (i + 1 < MAX_IDS) ? i + 1 : 0;
    end
    free_top = 1;

    // Key pool with near neighbors: shared address or shared port
    for (int i = 0; i < POOL_N; i++) begin
      key_ip[i]   = $urandom;
      key_port[i] = PORT_W'($urandom_range(0, 65535));
      if (i % 4 == 1) key_ip[i] = key_ip[i-1];
      if (i % 4 == 2) key_port[i] = key_port[i-1];
    end

    @(posedge clk);
    while (rst) @(posedge clk);

    // Directed table
    for (int i = 0; i < N_DIR; i++) begin
      row = DIR_ROWS[i];
      send_req(req_t'(row.req), row.ip, row.port, row.hdl, row.typed,
               '{row.st, row.id, row.conn, row.ho}, 1'b0);
    end

    // Random episodes: fill the table, drain it, mix
    sent = 0;
    while (sent < N_RANDOM) begin
      r      = $urandom_range(0, 99);
      mix    = (r < 40) ? MIX_BALANCED : (r < 70) ? MIX_FILL : MIX_DRAIN;
      r      = $urandom_range(0, 2);
      win    = (mix == MIX_FILL) ? POOL_N : (r == 0) ? 4 : (r == 1) ? 16 : POOL_N;
      base   = $urandom_range(0, POOL_N - 1);
      ep_len = $urandom_range(20, 120);
      quiet  = ($urandom_range(0, 9) == 0);
      for (int n = 0; n < ep_len && sent < N_RANDOM; n++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          // noise: disconnect, remove and find requests on random keys
          req  = req_t'($urandom_range(1, 3));
          ip   = $urandom;
          port = PORT_W'($urandom_range(0, 65535));
        end else begin
          k    = (base + $urandom_range(0, win - 1)) % POOL_N;
          ip   = key_ip[k];
          port = key_port[k];
          r    = $urandom_range(0, 99);
          case (mix)
            MIX_FILL:  req = (r < 70) ? REQ_CONNECT : (r < 80) ? REQ_DISCONNECT :
                             (r < 85) ? REQ_REMOVE : REQ_FIND;
            MIX_DRAIN: req = (r < 10) ? REQ_CONNECT : (r < 50) ? REQ_DISCONNECT :
                             (r < 85) ? REQ_REMOVE : REQ_FIND;
            default:   req = (r < 35) ? REQ_CONNECT : (r < 60) ? REQ_DISCONNECT :
                             (r < 80) ? REQ_REMOVE : REQ_FIND;
          endcase
        end
        send_req(req, ip, port, HDL_W'($urandom_range(0, 65535)), 1'b0, '0, quiet);
        sent++;
      end
    end
    s_tvalid <= 1'b0;

    // Drain, then let the block settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("[server_registry_with_id_allocator] OK");
    end else begin
      $display("[server_registry_with_id_allocator] ERROR");
    end
    $finish;
  end

  // Receiver: random ready, short and long stalls, one long hold-off
  initial begin
    bit hold_done;
    int r;
    int n;
    hold_done = 1'b0;
    m_tready  = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      r = $urandom_range(0, 199);
      if (!hold_done && n_results >= HOLD_AT) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (r < 2) begin
        m_tready <= 1'b1;
        repeat (200) @(posedge clk);
      end else if (r < 140) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        n = (r < 192) ? $urandom_range(1, 4) : $urandom_range(20, 80);
        repeat (n) @(posedge clk);
      end
    end
  end

  // Check each result item against the oldest expectation
  initial n_fail = 0;
  initial n_results = 0;
  always @(posedge clk) begin
    reg_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $display("unexpected result item: tdata=%h", m_tdata);
      end else begin
        e = pending_results.pop_front();
        if (m_tdata[3:0] !== e.st || m_tdata[9:4] !== e.id || m_tdata[10] !== e.conn ||
            m_tdata[26:11] !== e.ho || m_tdata[31:27] !== '0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display({"mismatch: exp st=%0d id=%0d conn=%0b hdl=%h / ",
                      "got st=%0d id=%0d conn=%0b hdl=%h pad=%h"},
                     e.st, e.id, e.conn, e.ho, m_tdata[3:0], m_tdata[9:4], m_tdata[10],
                     m_tdata[26:11], m_tdata[31:27]);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[server_registry_with_id_allocator] ERROR");
        $finish;
      end
    end
  end

endmodule

### server_registry_with_id_allocator.f
design/sra_pkg.sv
design/sra_ctrl.sv
design/sra_dpath.sv
design/server_registry_with_id_allocator.sv
dv/tb_top.sv
